### rtl/mfr_pkg.sv
// Shared types, kind codes and per-kind lookup functions for the MIDI event filter/remapper.
package mfr_pkg;

  localparam int KindW  = 5;
  localparam int NibW   = 4;
  localparam int ValW   = 14;
  localparam int CfgW   = 28;
  localparam int RegIdxW = 3;

  typedef logic [KindW-1:0] kind_t;
  typedef logic [NibW-1:0]  nib_t;
  typedef logic [ValW-1:0]  val_t;

  // Event kind codes in table order.
  localparam kind_t KIND_NONE    = 5'd0;
  localparam kind_t KIND_ANY     = 5'd1;
  localparam kind_t KIND_TEMPO   = 5'd2;
  localparam kind_t KIND_TIMESIG = 5'd3;
  localparam kind_t KIND_NRPN    = 5'd4;
  localparam kind_t KIND_NOTEOFF = 5'd8;
  localparam kind_t KIND_NOTE    = 5'd9;
  localparam kind_t KIND_KAT     = 5'd10;
  localparam kind_t KIND_CTL     = 5'd11;
  localparam kind_t KIND_PC      = 5'd12;
  localparam kind_t KIND_BEND    = 5'd14;

  // Configuration register indexes.
  localparam logic [RegIdxW-1:0] REG_FROM_KIND      = 3'd0;
  localparam logic [RegIdxW-1:0] REG_TO_KIND        = 3'd1;
  localparam logic [RegIdxW-1:0] REG_FROM_DEV_CH    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_FROM_V0        = 3'd3;
  localparam logic [RegIdxW-1:0] REG_FROM_V1        = 3'd4;
  localparam logic [RegIdxW-1:0] REG_TO_DEV_CH_BASE = 3'd5;
  localparam logic [RegIdxW-1:0] REG_TO_VALUE_BASE  = 3'd6;

  typedef struct packed {
    kind_t        from_kind;
    kind_t        to_kind;
    logic [15:0]  from_dev_ch_bounds;
    logic [27:0]  from_v0_bounds;
    logic [27:0]  from_v1_bounds;
    logic [7:0]   to_dev_ch_base;
    logic [27:0]  to_value_base;
  } cfg_t;

  typedef struct packed {
    kind_t kind;
    nib_t  device;
    nib_t  channel;
    val_t  first_value;
    val_t  second_value;
  } event_t;

  typedef struct packed {
    logic  matched;
    kind_t kind;
    nib_t  device;
    nib_t  channel;
    val_t  first_value;
    val_t  second_value;
  } result_t;

  // True for kinds that carry a device and a channel.
  function automatic logic kind_has_dc(input kind_t k);
    case (k) inside
      KIND_ANY, [KIND_NRPN:KIND_BEND]: return 1'b1;
      default:                         return 1'b0;
    endcase
  endfunction

  // Number of values a kind carries.
  function automatic logic [1:0] kind_nvals(input kind_t k);
    case (k) inside
      KIND_TEMPO, [KIND_PC:KIND_BEND]:  return 2'd1;
      KIND_TIMESIG, [KIND_NRPN:KIND_CTL]: return 2'd2;
      default:                          return 2'd0;
    endcase
  endfunction

endpackage

### rtl/midi_event_filter_remap_core.sv
// Top level of the MIDI event filter/remapper: input register, remap logic, result register.
// done rises when the result register loads the remapped word of an accepted start.
// Throughput: one word per clock cycle; busy is always low, so start is taken every cycle.
// The path is an input register, one level of compare/add logic and a result register.
// Reset (synchronous, active high) clears the pipeline valid bits and loads the
// configuration registers with their default specs; the receiver cannot stall.
module midi_event_filter_remap_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [mfr_pkg::KindW-1:0]    event_kind,
  input  logic [mfr_pkg::NibW-1:0]     event_device,
  input  logic [mfr_pkg::NibW-1:0]     event_channel,
  input  logic [mfr_pkg::ValW-1:0]     event_first_value,
  input  logic [mfr_pkg::ValW-1:0]     event_second_value,
  input  logic                         wr_en,
  input  logic [mfr_pkg::RegIdxW-1:0]  wr_index,
  input  logic [mfr_pkg::CfgW-1:0]     wr_data,
  output logic                         done,
  output logic                         matched,
  output logic [mfr_pkg::KindW-1:0]    mapped_kind,
  output logic [mfr_pkg::NibW-1:0]     mapped_device,
  output logic [mfr_pkg::NibW-1:0]     mapped_channel,
  output logic [mfr_pkg::ValW-1:0]     mapped_first_value,
  output logic [mfr_pkg::ValW-1:0]     mapped_second_value
);
  import mfr_pkg::*;

  cfg_t    cfg;
  event_t  ev_reg;
  logic    ev_valid;
  result_t res_comb;
  result_t res_reg;
  logic    accept;

  // The pipeline never stalls, so a word can be taken every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  mfr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= accept;
    end
    if (accept) begin
      ev_reg.kind         <= event_kind;
      ev_reg.device       <= event_device;
      ev_reg.channel      <= event_channel;
      ev_reg.first_value  <= event_first_value;
      ev_reg.second_value <= event_second_value;
    end
  end

  mfr_remap u_remap (
    .cfg (cfg),
    .ev  (ev_reg),
    .res (res_comb)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ev_valid;
    end
    if (ev_valid) begin
      res_reg <= res_comb;
    end
  end

  assign matched             = res_reg.matched;
  assign mapped_kind         = res_reg.kind;
  assign mapped_device       = res_reg.device;
  assign mapped_channel      = res_reg.channel;
  assign mapped_first_value  = res_reg.first_value;
  assign mapped_second_value = res_reg.second_value;

  // Every accepted word yields exactly one result, through the input and result registers.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted word produced no result");

  // A result that is not a match carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !matched) |-> (mapped_kind == '0 && mapped_device == '0 &&
      mapped_channel == '0 && mapped_first_value == '0 && mapped_second_value == '0))
    else $error("unmatched result has nonzero fields");

  // A source spec of kind none never matches.
  a_none_no_match: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cfg.from_kind) == KIND_NONE) |-> !matched)
    else $error("source kind none produced a match");

  // A result strobe is always preceded by a valid input stage.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ev_valid))
    else $error("result strobe without a word in the input stage");

endmodule

### rtl/mfr_cfg_regs.sv
// Configuration register file for the source and target specs.
module mfr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [mfr_pkg::RegIdxW-1:0]   wr_index,
  input  logic [mfr_pkg::CfgW-1:0]      wr_data,
  output mfr_pkg::cfg_t                 cfg
);
  import mfr_pkg::*;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.from_kind          <= KIND_ANY;
      cfg.to_kind            <= KIND_ANY;
      cfg.from_dev_ch_bounds <= 16'hF0F0;
      cfg.from_v0_bounds     <= '0;
      cfg.from_v1_bounds     <= '0;
      cfg.to_dev_ch_base     <= '0;
      cfg.to_value_base      <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FROM_KIND:      cfg.from_kind          <= wr_data[KindW-1:0];
        REG_TO_KIND:        cfg.to_kind            <= wr_data[KindW-1:0];
        REG_FROM_DEV_CH:    cfg.from_dev_ch_bounds <= wr_data[15:0];
        REG_FROM_V0:        cfg.from_v0_bounds     <= wr_data;
        REG_FROM_V1:        cfg.from_v1_bounds     <= wr_data;
        REG_TO_DEV_CH_BASE: cfg.to_dev_ch_base     <= wr_data[7:0];
        REG_TO_VALUE_BASE:  cfg.to_value_base      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/mfr_remap.sv
// Match test against the source spec and rewrite into the target spec.
module mfr_remap (
  input  mfr_pkg::cfg_t    cfg,
  input  mfr_pkg::event_t  ev,
  output mfr_pkg::result_t res
);
  import mfr_pkg::*;

  kind_t      fk, tk, out_kind;
  nib_t       fdmin, fdmax, fcmin, fcmax, tdmin, tcmin;
  val_t       f0min, f0max, f1min, f1max, t0min, t1min;
  logic       dc_f, dc_e, dc_o;
  logic [1:0] nv_f, nv_e, nv_t;
  logic       kind_ok, dc_ok, v0_ok, v1_ok, ok;
  nib_t       dev_shift, ch_shift;
  val_t       v0_shift, v1_shift;
  nib_t       od, oc;
  val_t       o0, o1;

  // Unpack the spec registers.
  always_comb begin
    fk    = cfg.from_kind;
    tk    = cfg.to_kind;
    fdmin = cfg.from_dev_ch_bounds[3:0];
    fdmax = cfg.from_dev_ch_bounds[7:4];
    fcmin = cfg.from_dev_ch_bounds[11:8];
    fcmax = cfg.from_dev_ch_bounds[15:12];
    f0min = cfg.from_v0_bounds[13:0];
    f0max = cfg.from_v0_bounds[27:14];
    f1min = cfg.from_v1_bounds[13:0];
    f1max = cfg.from_v1_bounds[27:14];
    tdmin = cfg.to_dev_ch_base[3:0];
    tcmin = cfg.to_dev_ch_base[7:4];
    t0min = cfg.to_value_base[13:0];
    t1min = cfg.to_value_base[27:14];
  end

  // Kind and range tests.
  always_comb begin
    dc_f = kind_has_dc(fk);
    dc_e = kind_has_dc(ev.kind);
    nv_f = kind_nvals(fk);
    nv_e = kind_nvals(ev.kind);
    nv_t = kind_nvals(tk);
    unique case (fk)
      KIND_NONE: kind_ok = 1'b0;
      KIND_ANY:  kind_ok = 1'b1;
      KIND_NOTE: kind_ok = (ev.kind == KIND_NOTEOFF) || (ev.kind == KIND_NOTE)
                           || (ev.kind == KIND_KAT);
      default:   kind_ok = (fk == ev.kind);
    endcase
    dc_ok = !(dc_f && dc_e) ||
            (ev.device >= fdmin && ev.device <= fdmax &&
             ev.channel >= fcmin && ev.channel <= fcmax);
    v0_ok = !(nv_f != 2'd0 && nv_e != 2'd0) ||
            (ev.first_value >= f0min && ev.first_value <= f0max);
    v1_ok = !(nv_f == 2'd2 && nv_e == 2'd2) ||
            (ev.second_value >= f1min && ev.second_value <= f1max);
    ok = kind_ok && dc_ok && v0_ok && v1_ok;
    // Any and note specs keep the event kind; an exact spec takes the target kind.
    out_kind = (fk == KIND_ANY || fk == KIND_NOTE) ? ev.kind : tk;
  end

  // Offsets from the source minima; all sums wrap at the field width.
  always_comb begin
    dev_shift = ev.device - fdmin;
    ch_shift  = ev.channel - fcmin;
    v0_shift  = ev.first_value - f0min;
    v1_shift  = ev.second_value - f1min;
  end

  // Rewrite into the target spec.
  always_comb begin
    od = '0;
    oc = '0;
    o0 = '0;
    o1 = '0;
    if (fk == KIND_ANY) begin
      od       = dev_shift + tdmin;
      oc       = ch_shift + tcmin;
      o0       = ev.first_value;
      o1       = ev.second_value;
    end else begin
      if (dc_o) begin
        od = dc_f ? (tdmin + dev_shift) : tdmin;
        oc = dc_f ? (tcmin + ch_shift) : tcmin;
      end
      case (nv_f)
        2'd0: begin
          if (nv_t != 2'd0) o0 = t0min;
          if (nv_t == 2'd2) o1 = t1min;
        end
        2'd1: begin
          if (nv_t == 2'd1) begin
            o0 = v0_shift + t0min;
          end else if (nv_t == 2'd2) begin
            o0 = t0min;
            o1 = v0_shift + t1min;
          end
        end
        default: begin
          if (nv_t == 2'd1) begin
            o0 = v1_shift + t0min;
          end else if (nv_t == 2'd2) begin
            o0 = v0_shift + t0min;
            o1 = v1_shift + t1min;
          end
        end
      endcase
    end
  end

  assign dc_o = kind_has_dc(out_kind);

  // A miss clears every field of the result.
  always_comb begin
    res.matched      = ok;
    res.kind         = ok ? out_kind : '0;
    res.device       = ok ? od : '0;
    res.channel      = ok ? oc : '0;
    res.first_value  = ok ? o0 : '0;
    res.second_value = ok ? o1 : '0;
  end

endmodule

### tb/sv/midi_event_filter_remap_core_tb.sv
// Self-checking testbench for the MIDI event filter/remap core, with its own remap predictor.
module midi_event_filter_remap_core_tb;
  import mfr_pkg::*;

  // Kind codes that the package leaves unnamed.
  localparam kind_t KIND_CAT       = 5'd13;
  localparam kind_t KIND_UNUSED    = 5'd15;
  localparam kind_t KIND_SYSEX_TOP = 5'd31;

  localparam int unsigned ITEM_TARGET = 1450;
  localparam cfg_t CFG_AT_RESET = {5'd1, 5'd1, 16'hF0F0, 28'd0, 28'd0, 8'd0, 28'd0};

  typedef enum logic [1:0] {OP_EVENT, OP_WRITE, OP_DRAIN} stim_op_t;

  typedef struct packed {
    stim_op_t             op;
    logic [7:0]           gap;
    event_t               evt;
    logic [RegIdxW-1:0]   idx;
    logic [CfgW-1:0]      data;
  } stim_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  kind_t              event_kind = '0;
  nib_t               event_device = '0;
  nib_t               event_channel = '0;
  val_t               event_first_value = '0;
  val_t               event_second_value = '0;
  logic               wr_en = 1'b0;
  logic [RegIdxW-1:0] wr_index = '0;
  logic [CfgW-1:0]    wr_data = '0;
  logic               done;
  logic               matched;
  kind_t              mapped_kind;
  nib_t               mapped_device;
  nib_t               mapped_channel;
  val_t               mapped_first_value;
  val_t               mapped_second_value;

  stim_t       stim_q[$];
  result_t     predicted_remaps[$];
  stim_t       cur_entry;
  logic        have_cur = 1'b0;
  int unsigned gap_left = 0;
  cfg_t        live_cfg = CFG_AT_RESET;
  cfg_t        plan_cfg = CFG_AT_RESET;
  int unsigned words_sent = 0;
  int unsigned remaps_seen = 0;
  int unsigned fault_count = 0;
  int unsigned item_total = 0;

  midi_event_filter_remap_core DUT (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .event_kind          (event_kind),
    .event_device        (event_device),
    .event_channel       (event_channel),
    .event_first_value   (event_first_value),
    .event_second_value  (event_second_value),
    .wr_en               (wr_en),
    .wr_index            (wr_index),
    .wr_data             (wr_data),
    .done                (done),
    .matched             (matched),
    .mapped_kind         (mapped_kind),
    .mapped_device       (mapped_device),
    .mapped_channel      (mapped_channel),
    .mapped_first_value  (mapped_first_value),
    .mapped_second_value (mapped_second_value)
  );

  always #10 clk = ~clk;

  // Kinds that carry a device and a channel.
  function automatic logic carries_dev_ch(input kind_t k);
    return (k == KIND_ANY) || (k >= KIND_NRPN && k <= KIND_BEND);
  endfunction

  // Number of values a kind carries.
  function automatic logic [1:0] value_count(input kind_t k);
    if (k == KIND_TEMPO || k == KIND_PC || k == KIND_CAT || k == KIND_BEND) return 2'd1;
    if (k == KIND_TIMESIG || (k >= KIND_NRPN && k <= KIND_CTL)) return 2'd2;
    return 2'd0;
  endfunction

  // Configuration after one register write; bits above the register width are dropped.
  function automatic cfg_t cfg_after_write(input cfg_t c, input logic [RegIdxW-1:0] idx,
                                           input logic [CfgW-1:0] d);
    cfg_t n;
    n = c;
    case (idx)
      REG_FROM_KIND:      n.from_kind = d[4:0];
      REG_TO_KIND:        n.to_kind = d[4:0];
      REG_FROM_DEV_CH:    n.from_dev_ch_bounds = d[15:0];
      REG_FROM_V0:        n.from_v0_bounds = d;
      REG_FROM_V1:        n.from_v1_bounds = d;
      REG_TO_DEV_CH_BASE: n.to_dev_ch_base = d[7:0];
      REG_TO_VALUE_BASE:  n.to_value_base = d;
      default: ;
    endcase
    return n;
  endfunction

  // Filters one event against the source spec and rewrites it into the target spec.
  function automatic result_t remap_event(input cfg_t c, input event_t e);
    kind_t      fk, tk, out_kind;
    nib_t       fdmin, fdmax, fcmin, fcmax, tdmin, tcmin;
    val_t       f0min, f0max, f1min, f1max, t0min, t1min;
    logic [1:0] nf, nt;
    logic       hit;
    result_t    r;
    fk = c.from_kind;
    tk = c.to_kind;
    {fcmax, fcmin, fdmax, fdmin} = c.from_dev_ch_bounds;
    {f0max, f0min} = c.from_v0_bounds;
    {f1max, f1min} = c.from_v1_bounds;
    {tcmin, tdmin} = c.to_dev_ch_base;
    {t1min, t0min} = c.to_value_base;
    r = '0;

    // Kind test, then the ranges that both kinds carry.
    if (fk == KIND_NONE) hit = 1'b0;
    else if (fk == KIND_NOTE)
      hit = (e.kind == KIND_NOTEOFF) || (e.kind == KIND_NOTE) || (e.kind == KIND_KAT);
    else hit = (fk == KIND_ANY) || (fk == e.kind);
    if (hit && carries_dev_ch(fk) && carries_dev_ch(e.kind))
      hit = (e.device >= fdmin) && (e.device <= fdmax) &&
            (e.channel >= fcmin) && (e.channel <= fcmax);
    if (hit && value_count(fk) > 0 && value_count(e.kind) > 0)
      hit = (e.first_value >= f0min) && (e.first_value <= f0max);
    if (hit && value_count(fk) > 1 && value_count(e.kind) > 1)
      hit = (e.second_value >= f1min) && (e.second_value <= f1max);
    if (!hit) return r;

    r.matched = 1'b1;
    // Source kind any keeps kind and values and shifts device and channel.
    if (fk == KIND_ANY) begin
      r.kind = e.kind;
      r.device = e.device - fdmin + tdmin;
      r.channel = e.channel - fcmin + tcmin;
      r.first_value = e.first_value;
      r.second_value = e.second_value;
      return r;
    end

    out_kind = (fk == KIND_NOTE) ? e.kind : tk;
    r.kind = out_kind;
    if (carries_dev_ch(out_kind)) begin
      r.device = tdmin;
      r.channel = tcmin;
      if (carries_dev_ch(fk)) begin
        r.device = tdmin + e.device - fdmin;
        r.channel = tcmin + e.channel - fcmin;
      end
    end

    // Values move between one-value and two-value kinds.
    nf = value_count(fk);
    nt = value_count(tk);
    case (nf)
      2'd0: begin
        if (nt >= 2'd1) r.first_value = t0min;
        if (nt == 2'd2) r.second_value = t1min;
      end
      2'd1: begin
        if (nt == 2'd1) r.first_value = e.first_value - f0min + t0min;
        else if (nt == 2'd2) begin
          r.first_value = t0min;
          r.second_value = e.first_value - f0min + t1min;
        end
      end
      default: begin
        if (nt == 2'd1) r.first_value = e.second_value - f1min + t0min;
        else if (nt == 2'd2) begin
          r.first_value = e.first_value - f0min + t0min;
          r.second_value = e.second_value - f1min + t1min;
        end
      end
    endcase
    return r;
  endfunction

  // Idle time before a word: mostly none, sometimes short, rarely long.
  function automatic logic [7:0] pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'd0;
    if (r < 85) return 8'($urandom_range(1, 3));
    if (r < 97) return 8'($urandom_range(4, 10));
    return 8'($urandom_range(20, 60));
  endfunction

  // A value inside [lo, hi], or any value when the range is empty.
  function automatic int unsigned pick_in(input int unsigned lo, hi, top);
    if (lo <= hi) return $urandom_range(hi, lo);
    return $urandom_range(top, 0);
  endfunction

  // Packed {max, min} nibble range: usually ordered, sometimes full, a point or reversed.
  function automatic logic [7:0] nib_bounds();
    int unsigned r;
    nib_t        lo, hi;
    r = $urandom_range(0, 9);
    lo = 4'($urandom);
    hi = 4'($urandom_range(15, lo));
    if (r == 0) begin
      lo = 4'd0;
      hi = 4'd15;
    end else if (r == 1) begin
      hi = lo;
    end else if (r == 2 && lo != 4'd0) begin
      hi = 4'($urandom_range(lo - 1, 0));
    end
    return {hi, lo};
  endfunction

  // Packed {max, min} value range, with 7-bit ranges common.
  function automatic logic [27:0] val_bounds();
    int unsigned r;
    val_t        lo, hi;
    r = $urandom_range(0, 9);
    lo = (r < 5) ? 14'($urandom_range(0, 127)) : 14'($urandom);
    hi = 14'($urandom_range(16383, lo));
    if (r < 4) hi = 14'($urandom_range(lo + 127 > 16383 ? 16383 : lo + 127, lo));
    if (r == 5) begin
      lo = 14'd0;
      hi = 14'h3FFF;
    end else if (r == 6) begin
      hi = lo;
    end else if (r == 7 && lo != 14'd0) begin
      hi = 14'($urandom_range(lo - 1, 0));
    end
    return {hi, lo};
  endfunction

  task automatic queue_write(input logic [RegIdxW-1:0] idx, input logic [CfgW-1:0] value,
                             input int unsigned width);
    stim_t          s;
    logic [CfgW-1:0] mask;
    mask = (width >= CfgW) ? '1 : ((28'd1 << width) - 28'd1);
    s = '0;
    s.op = OP_WRITE;
    s.idx = idx;
    // Bits above the register width carry random junk.
    s.data = (28'($urandom) & ~mask) | (value & mask);
    stim_q.push_back(s);
    plan_cfg = cfg_after_write(plan_cfg, idx, s.data);
  endtask

  task automatic queue_config(input kind_t fk, tk, input logic [15:0] fdc,
                              input logic [27:0] f0, f1, input logic [7:0] tdc,
                              input logic [27:0] tv);
    queue_write(REG_FROM_KIND, 28'(fk), 5);
    queue_write(REG_TO_KIND, 28'(tk), 5);
    queue_write(REG_FROM_DEV_CH, 28'(fdc), 16);
    queue_write(REG_FROM_V0, f0, 28);
    queue_write(REG_FROM_V1, f1, 28);
    queue_write(REG_TO_DEV_CH_BASE, 28'(tdc), 8);
    queue_write(REG_TO_VALUE_BASE, tv, 28);
  endtask

  task automatic queue_drain();
    stim_t s;
    s = '0;
    s.op = OP_DRAIN;
    stim_q.push_back(s);
  endtask

  task automatic queue_event(input event_t e, input logic [7:0] gap);
    stim_t s;
    s = '0;
    s.op = OP_EVENT;
    s.gap = gap;
    s.evt = e;
    stim_q.push_back(s);
    item_total++;
  endtask

  task automatic queue_directed(input kind_t k, input nib_t d, c, input val_t v0, v1);
    queue_event({k, d, c, v0, v1}, pick_gap());
  endtask

  // Random spec with bias toward the kinds and ranges that lead to matches.
  task automatic queue_random_config();
    kind_t       fk, tk;
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) fk = KIND_NONE;
    else if (r < 5) fk = KIND_ANY;
    else if (r < 9) fk = KIND_NOTE;
    else if (r < 17) fk = kind_t'($urandom_range(2, 15));
    else fk = 5'($urandom);
    r = $urandom_range(0, 19);
    if (r < 3) tk = KIND_ANY;
    else if (r < 17) tk = kind_t'($urandom_range(0, 15));
    else tk = 5'($urandom);
    queue_config(fk, tk, {nib_bounds(), nib_bounds()}, val_bounds(), val_bounds(),
                 8'($urandom), 28'($urandom));
  endtask

  // Mostly events shaped to pass the planned source spec, the rest noise and extremes.
  task automatic queue_random_event(input logic [7:0] gap);
    event_t      e;
    int unsigned r;
    r = $urandom_range(0, 99);
    e = {5'($urandom), 4'($urandom), 4'($urandom), 14'($urandom), 14'($urandom)};
    if (r < 75) begin
      case (plan_cfg.from_kind)
        KIND_NONE, KIND_ANY: ;
        KIND_NOTE: e.kind = KIND_NOTEOFF + kind_t'($urandom_range(0, 2));
        default:   e.kind = plan_cfg.from_kind;
      endcase
      e.device = nib_t'(pick_in(plan_cfg.from_dev_ch_bounds[3:0],
                                plan_cfg.from_dev_ch_bounds[7:4], 15));
      e.channel = nib_t'(pick_in(plan_cfg.from_dev_ch_bounds[11:8],
                                 plan_cfg.from_dev_ch_bounds[15:12], 15));
      e.first_value = val_t'(pick_in(plan_cfg.from_v0_bounds[13:0],
                                     plan_cfg.from_v0_bounds[27:14], 16383));
      e.second_value = val_t'(pick_in(plan_cfg.from_v1_bounds[13:0],
                                      plan_cfg.from_v1_bounds[27:14], 16383));
    end else if (r < 80) begin
      e = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end
    queue_event(e, gap);
  endtask

  // Sender: offers one word per event entry and issues register writes only when idle.
  always @(posedge clk) begin : stim_drive
    logic launch;
    logic write_now;
    launch = 1'b0;
    write_now = 1'b0;
    if (rst) begin
      have_cur = 1'b0;
      gap_left = 0;
      live_cfg = CFG_AT_RESET;
      words_sent <= 0;
      start <= 1'b0;
      wr_en <= 1'b0;
      wr_index <= '0;
      wr_data <= '0;
      event_kind <= '0;
      event_device <= '0;
      event_channel <= '0;
      event_first_value <= '0;
      event_second_value <= '0;
    end else begin
      // The word on the inputs is taken at this edge: predict its result.
      if (start && !busy) begin
        predicted_remaps.push_back(remap_event(live_cfg, {event_kind, event_device,
            event_channel, event_first_value, event_second_value}));
        words_sent <= words_sent + 1;
      end
      if (start && busy) begin
        launch = 1'b1;
      end else begin
        if (!have_cur && stim_q.size() != 0) begin
          cur_entry = stim_q.pop_front();
          have_cur = 1'b1;
          gap_left = cur_entry.gap;
        end
        if (have_cur) begin
          if (gap_left != 0) begin
            gap_left = gap_left - 1;
          end else if (cur_entry.op == OP_EVENT) begin
            launch = 1'b1;
            have_cur = 1'b0;
            event_kind <= cur_entry.evt.kind;
            event_device <= cur_entry.evt.device;
            event_channel <= cur_entry.evt.channel;
            event_first_value <= cur_entry.evt.first_value;
            event_second_value <= cur_entry.evt.second_value;
          end else if (!start && words_sent == remaps_seen) begin
            // Every word has its result back, so the block is idle.
            if (cur_entry.op == OP_WRITE) begin
              write_now = 1'b1;
              wr_index <= cur_entry.idx;
              wr_data <= cur_entry.data;
              live_cfg = cfg_after_write(live_cfg, cur_entry.idx, cur_entry.data);
            end
            have_cur = 1'b0;
          end
        end
      end
      start <= launch;
      wr_en <= write_now;
    end
  end

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  // Receiver: compares each result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (predicted_remaps.size() == 0) begin
        $error("result word with no prediction waiting: matched %0d kind %0d",
               matched, mapped_kind);
        fault_count++;
      end else begin
        want = predicted_remaps.pop_front();
        check_field("matched", want.matched, matched);
        check_field("mapped_kind", want.kind, mapped_kind);
        check_field("mapped_device", want.device, mapped_device);
        check_field("mapped_channel", want.channel, mapped_channel);
        check_field("mapped_first_value", want.first_value, mapped_first_value);
        check_field("mapped_second_value", want.second_value, mapped_second_value);
        remaps_seen <= remaps_seen + 1;
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin : run_plan
    int unsigned n;
    logic        quiet;

    // Default spec: everything passes through unchanged.
    queue_directed(KIND_NONE, 4'd0, 4'd0, 14'd0, 14'd0);
    queue_directed(KIND_SYSEX_TOP, 4'd15, 4'd15, 14'h3FFF, 14'h3FFF);
    queue_directed(KIND_NOTE, 4'd3, 4'd7, 14'd60, 14'd100);
    queue_drain();

    // Any to any with shifts that wrap; the device range only applies to kinds with a device.
    queue_config(KIND_ANY, KIND_ANY, {4'd15, 4'd1, 4'd14, 4'd2}, 28'd0, 28'd0,
                 {4'd15, 4'd15}, 28'd0);
    queue_directed(KIND_CTL, 4'd15, 4'd15, 14'd5, 14'd6);
    queue_directed(KIND_CTL, 4'd14, 4'd1, 14'd5, 14'd6);
    queue_directed(KIND_TEMPO, 4'd15, 4'd0, 14'd9, 14'd9);
    queue_directed(KIND_ANY, 4'd2, 4'd0, 14'd1, 14'd2);

    // Source kind none matches nothing.
    queue_config(KIND_NONE, KIND_ANY, 16'hF0F0, 28'd0, 28'd0, 8'd0, 28'd0);
    queue_directed(KIND_NOTE, 4'd0, 4'd0, 14'd0, 14'd0);
    queue_directed(KIND_SYSEX_TOP, 4'd0, 4'd0, 14'd0, 14'd0);

    // Note family to controller, with value ranges at their edges and a wrapping sum.
    queue_config(KIND_NOTE, KIND_CTL, {4'd3, 4'd0, 4'd15, 4'd0}, {14'd72, 14'd48},
                 {14'h3FFF, 14'd1}, {4'd9, 4'd0}, {14'd7, 14'd16380});
    queue_directed(KIND_NOTEOFF, 4'd2, 4'd0, 14'd48, 14'd1);
    queue_directed(KIND_KAT, 4'd0, 4'd3, 14'd72, 14'h3FFF);
    queue_directed(KIND_NOTE, 4'd0, 4'd4, 14'd60, 14'd64);
    queue_directed(KIND_CTL, 4'd0, 4'd0, 14'd60, 14'd64);
    queue_directed(KIND_NOTE, 4'd0, 4'd0, 14'd60, 14'd0);

    // One-value bend into a two-value note.
    queue_config(KIND_BEND, KIND_NOTE, 16'hF0F0, {14'h3FFF, 14'd0}, 28'd0,
                 {4'd2, 4'd1}, {14'd100, 14'd10});
    queue_directed(KIND_BEND, 4'd5, 4'd5, 14'h3FFF, 14'd77);
    queue_directed(KIND_PC, 4'd5, 4'd5, 14'd3, 14'd77);

    // Two-value controller into a one-value program change.
    queue_config(KIND_CTL, KIND_PC, 16'hF0F0, {14'h3FFF, 14'd0}, {14'd127, 14'd0},
                 8'd0, {14'd0, 14'd5});
    queue_directed(KIND_CTL, 4'd1, 4'd1, 14'd7, 14'd127);
    queue_directed(KIND_CTL, 4'd1, 4'd1, 14'd7, 14'd128);

    // Tempo into time signature: no device or channel on either side.
    queue_config(KIND_TEMPO, KIND_TIMESIG, 16'hF0F0, {14'd200, 14'd100}, 28'd0,
                 8'hFF, {14'd3, 14'd4});
    queue_directed(KIND_TEMPO, 4'd9, 4'd9, 14'd150, 14'd3);

    // A reversed first-value range matches nothing.
    queue_config(KIND_TIMESIG, KIND_UNUSED, 16'hF0F0, {14'd0, 14'd1}, {14'h3FFF, 14'd0},
                 8'd0, 28'd0);
    queue_directed(KIND_TIMESIG, 4'd0, 4'd0, 14'd0, 14'd0);

    // A sysex slot kind into any: base device and channel, no values.
    queue_config(KIND_SYSEX_TOP, KIND_ANY, 16'h0000, 28'd0, 28'd0, 8'h5A, 28'hFFFFFFF);
    queue_directed(KIND_SYSEX_TOP, 4'd15, 4'd15, 14'h3FFF, 14'h3FFF);

    // Extreme settings, then random phases until the item budget is spent.
    queue_config(KIND_NONE, KIND_NONE, 16'h0000, 28'd0, 28'd0, 8'd0, 28'd0);
    for (int i = 0; i < 20; i++) queue_random_event(pick_gap());
    queue_config(KIND_SYSEX_TOP, KIND_SYSEX_TOP, 16'hFFFF, 28'hFFFFFFF, 28'hFFFFFFF,
                 8'hFF, 28'hFFFFFFF);
    for (int i = 0; i < 20; i++) queue_random_event(pick_gap());
    while (item_total < ITEM_TARGET) begin
      queue_random_config();
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 80);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) == 0) queue_drain();
        queue_random_event(quiet ? 8'd0 : pick_gap());
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || have_cur || start || words_sent != remaps_seen)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (predicted_remaps.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_remaps.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin : watchdog
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
